@@ sv/ipv4_longest_prefix_match_table_assert.svh @@
// Assertion macros for the IPv4 longest prefix match table
`ifndef IPV4_LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH
`define IPV4_LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ipv4_lpm_pkg.sv @@
// Types and constants shared by the IPv4 longest prefix match table
package ipv4_lpm_pkg;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_FIND  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADLEN = 2'd3;

	localparam logic [5:0] MAX_LEN = 6'd32;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic [5:0]  prefix_len;
	} lpm_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] match_address;
		logic [5:0]  match_len;
		logic [1:0]  status;
	} lpm_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [5:0]  len;
		logic [31:0] address;
	} lpm_entry_t;

	typedef struct packed {
		logic load;
		logic wipe;
		logic rd;
		logic finish;
	} lpm_cmd_t;

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'h0000_0000;
		end else if (len > MAX_LEN) begin
			m = 32'hffff_ffff;
		end else begin
			m = 32'hffff_ffff << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage

@@ sv/ipv4_lpm_dp.sv @@
// Datapath: route memory, scan evaluation and result register
module ipv4_lpm_dp import ipv4_lpm_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lpm_cmd_t                                cmd,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] idx,
	input  lpm_req_t                                req,
	output lpm_rsp_t                                rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	lpm_entry_t entry_mem [ENTRIES];
	lpm_entry_t rd_data_s1;
	logic       eval_s1;

	lpm_req_t   req_q;
	logic       dup_q;
	logic       free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] idx_s1;
	logic       best_hit_q;
	logic [5:0] best_len_q;
	logic [31:0] best_addr_q;
	lpm_rsp_t   rsp_q;

	logic       we;
	logic [IW-1:0] waddr;
	lpm_entry_t wdata;
	logic       add_ok;
	logic       bad_len;
	logic       dup_hit;
	logic       find_hit;
	logic [31:0] diff;
	lpm_rsp_t   rsp_d;

	assign bad_len = (req_q.prefix_len == 6'd0) || (req_q.prefix_len > MAX_LEN);
	assign add_ok  = (req_q.func == FUNC_ADD) && !bad_len && !dup_q && free_found_q;

	assign we    = cmd.wipe || (cmd.finish && add_ok);
	assign waddr = cmd.wipe ? idx : free_idx_q;
	always_comb begin
		wdata = '0;
		if (!cmd.wipe) begin
			wdata.valid   = 1'b1;
			wdata.len     = req_q.prefix_len;
			wdata.address = req_q.address;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem[waddr] <= wdata;
		end
		rd_data_s1 <= entry_mem[idx];
		idx_s1     <= idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.rd;
		end
	end

	assign diff    = rd_data_s1.address ^ req_q.address;
	assign dup_hit = rd_data_s1.valid && (rd_data_s1.len == req_q.prefix_len) &&
		((diff & len_mask(req_q.prefix_len)) == 32'd0);
	assign find_hit = rd_data_s1.valid && (rd_data_s1.len != 6'd0) &&
		(rd_data_s1.len <= MAX_LEN) && (rd_data_s1.len > best_len_q) &&
		((diff & len_mask(rd_data_s1.len)) == 32'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q        <= req;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_hit_q   <= 1'b0;
			best_len_q   <= 6'd0;
			best_addr_q  <= 32'd0;
		end else if (eval_s1) begin
			if (dup_hit) begin
				dup_q <= 1'b1;
			end
			if (!rd_data_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (find_hit) begin
				best_hit_q  <= 1'b1;
				best_len_q  <= rd_data_s1.len;
				best_addr_q <= rd_data_s1.address;
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		case (req_q.func)
			FUNC_ADD: begin
				if (bad_len) begin
					rsp_d.status = ST_BADLEN;
				end else if (dup_q) begin
					rsp_d.status = ST_DUP;
				end else if (!free_found_q) begin
					rsp_d.status = ST_FULL;
				end else begin
					rsp_d.status = ST_OK;
				end
			end
			FUNC_FIND: begin
				rsp_d.hit           = best_hit_q;
				rsp_d.match_address = best_addr_q;
				rsp_d.match_len     = best_len_q;
				rsp_d.status        = ST_OK;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/ipv4_lpm_ctrl.sv @@
// Controller: sequences reset sweep, table scans, clears and result strobes
module ipv4_lpm_ctrl import ipv4_lpm_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [1:0]                              func,
	output logic                                    busy,
	output logic                                    done,
	output lpm_cmd_t                                cmd,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] idx
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cnt_q;
	lpm_cmd_t      cmd_q;
	logic          reply_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			cnt_q   <= '0;
			cmd_q   <= '{load: 1'b0, wipe: 1'b1, rd: 1'b0, finish: 1'b0};
			reply_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_WIPE: begin
					if (cnt_q == LAST) begin
						cnt_q      <= '0;
						cmd_q.wipe <= 1'b0;
						if (reply_q) begin
							state_q      <= S_DONE;
							cmd_q.finish <= 1'b1;
						end else begin
							state_q    <= S_IDLE;
							cmd_q.load <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q.load <= 1'b0;
						cnt_q      <= '0;
						unique case (func) inside
							FUNC_ADD, FUNC_FIND: begin
								state_q  <= S_SCAN;
								cmd_q.rd <= 1'b1;
							end
							FUNC_CLEAR: begin
								state_q    <= S_WIPE;
								cmd_q.wipe <= 1'b1;
								reply_q    <= 1'b1;
							end
							default: begin
								state_q      <= S_DONE;
								cmd_q.finish <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST) begin
						cnt_q    <= '0;
						cmd_q.rd <= 1'b0;
						state_q  <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_DRAIN: begin
					state_q      <= S_DONE;
					cmd_q.finish <= 1'b1;
				end
				S_DONE: begin
					cmd_q.finish <= 1'b0;
					cmd_q.load   <= 1'b1;
					reply_q      <= 1'b0;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
					cmd_q   <= '{load: 1'b1, wipe: 1'b0, rd: 1'b0, finish: 1'b0};
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign cmd  = cmd_q;
	assign idx  = cnt_q;

endmodule

@@ sv/ipv4_longest_prefix_match_table.sv @@
// Top level of the IPv4 longest prefix match route table
//
// Items enter on req (func, address, prefix_len) and are taken at a rising
// edge where start is high and busy is low. Each item gives exactly one
// result on rsp, shown for one cycle with done high; the receiver cannot
// stall, so a result must be taken in that cycle.
// Add and find read the route memory one entry per cycle through its single
// read port, then drain the last read before the strobe. Clear writes every
// entry invalid, one per cycle, and then strobes. The unused selector
// strobes without touching the memory. busy falls in the strobe cycle, so
// a new item can be taken there; the block takes no new item before then.
// After reset the block sweeps the memory once, marking all routes
// invalid, and holds busy high until the sweep ends.
// Find returns the stored address and length of the longest match, or zeros
// on a miss. Add reports bad length, duplicate or table full in status.
module ipv4_longest_prefix_match_table import ipv4_lpm_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  lpm_req_t req,
	output logic     busy,
	output logic     done,
	output lpm_rsp_t rsp
);

	`include "ipv4_longest_prefix_match_table_assert.svh"

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	lpm_cmd_t      cmd;
	logic [IW-1:0] idx;

	ipv4_lpm_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (req.func),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.idx   (idx)
	);

	ipv4_lpm_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.idx   (idx),
		.req   (req),
		.rsp   (rsp)
	);

	`LPM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")
	`LPM_ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done, "result strobe lasted two cycles")
	`LPM_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`LPM_ASSERT_NOW(a_hit_len, clk, arst_n, done && rsp.hit, (rsp.status == ST_OK) && (rsp.match_len != 6'd0) && (rsp.match_len <= MAX_LEN), "hit with bad length or status")

endmodule
